// ----- hdl/rgbe_pkg.sv -----
// rgbe_pkg: shared types, codes and the float conversion for the rgbe decoder
// depends on nothing; used by rgbe_pack and rgbe_scanline_rle_decoder
package rgbe_pkg;

  typedef enum logic [2:0] {
    PH_HDR,
    PH_CODE,
    PH_RUNVAL,
    PH_LIT,
    PH_FLAT
  } phase_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FILL,
    ST_EMIT
  } state_t;

  localparam logic [1:0] ERR_NONE  = 2'd0;
  localparam logic [1:0] ERR_WIDTH = 2'd1;
  localparam logic [1:0] ERR_COUNT = 2'd2;
  localparam logic [1:0] ERR_STORE = 2'd3;

  localparam logic [7:0] RUN_BASE = 8'd128;

  // one pixel on its way from the sequencer to the packer
  typedef struct packed {
    logic        use_ram;
    logic [23:0] rgb;
    logic [7:0]  expo;
    logic        row_end;
    logic        image_end;
    logic        last;
    logic [1:0]  err;
  } pix_t;

  // exact single of m * 2^(e-136), +0 for zero mantissa or exponent
  function automatic logic [31:0] to_float(input logic [7:0] m, input logic [7:0] e);
    logic [2:0]  k;
    logic [8:0]  sum;
    logic [7:0]  bexp;
    logic [31:0] m32;
    logic [31:0] sh;
    logic [31:0] res;
    k   = 3'd0;
    for (int i = 0; i < 8; i++) begin
      if (m[i]) k = 3'(i);
    end
    sum  = {1'b0, e} + {6'd0, k};
    bexp = 8'(sum - 9'd9);
    m32  = {24'd0, m};
    if (m == 8'd0 || e == 8'd0) begin
      res = 32'd0;
    end else if (sum >= 9'd10) begin
      sh  = m32 << (5'd23 - {2'd0, k});
      res = {1'b0, bexp, sh[22:0]};
    end else begin
      res = m32 << ({1'b0, e[3:0]} + 5'd13);
    end
    return res;
  endfunction

endpackage

// ----- hdl/rgbe_ram.sv -----
// rgbe_ram: generic single-write, single-read ram with registered read data
// no dependencies
module rgbe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

endmodule

// ----- hdl/rgbe_pack.sv -----
// rgbe_pack: converts pixels to float bits and packs them up to two per result
// depends on rgbe_pkg; holds the output register of the decoder
module rgbe_pack (
  input  logic               clk,
  input  logic               rst,
  input  logic               pix_valid,
  input  rgbe_pkg::pix_t     pix,
  input  logic [23:0]        ram_rgb,
  output logic               pix_take,
  output logic               pixel_valid,
  input  logic               pixel_stall,
  output logic [31:0]        red_a,
  output logic [31:0]        green_a,
  output logic [31:0]        blue_a,
  output logic [31:0]        red_b,
  output logic [31:0]        green_b,
  output logic [31:0]        blue_b,
  output logic               second_valid,
  output logic               row_end,
  output logic               image_end,
  output logic [1:0]         error_code,
  output logic               last
);
  import rgbe_pkg::*;

  logic [23:0] mant;
  logic [31:0] cr, cg, cb;
  logic        hold_a;
  logic [31:0] ha_r, ha_g, ha_b;
  logic        closes, needs_out, out_free;

  assign mant      = pix.use_ram ? ram_rgb : pix.rgb;
  assign cr        = to_float(mant[23:16], pix.expo);
  assign cg        = to_float(mant[15:8], pix.expo);
  assign cb        = to_float(mant[7:0], pix.expo);
  assign closes    = pix.row_end || pix.last;
  assign needs_out = hold_a || closes;
  assign out_free  = !pixel_valid || !pixel_stall;
  assign pix_take  = pix_valid && (!needs_out || out_free);

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_valid <= 1'b0;
      hold_a      <= 1'b0;
    end else begin
      pixel_valid <= (pixel_valid && pixel_stall) || (pix_take && needs_out);
      if (pix_take) hold_a <= !hold_a && !closes;
    end
  end

  always_ff @(posedge clk) begin
    // first pixel of a pair waits here
    if (pix_take && !hold_a) begin
      ha_r <= cr;
      ha_g <= cg;
      ha_b <= cb;
    end
    // result register only changes when a transaction is formed
    if (pix_take && needs_out) begin
      if (hold_a) begin
        red_a        <= ha_r;
        green_a      <= ha_g;
        blue_a       <= ha_b;
        red_b        <= cr;
        green_b      <= cg;
        blue_b       <= cb;
        second_valid <= 1'b1;
      end else begin
        red_a        <= cr;
        green_a      <= cg;
        blue_a       <= cb;
        red_b        <= 32'd0;
        green_b      <= 32'd0;
        blue_b       <= 32'd0;
        second_valid <= 1'b0;
      end
      row_end    <= pix.row_end;
      image_end  <= pix.image_end;
      error_code <= pix.err;
      last       <= pix.last;
    end
  end

endmodule

// ----- hdl/rgbe_scanline_rle_decoder.sv -----
// rgbe_scanline_rle_decoder: top level, byte sequencer, line store and packer
// depends on rgbe_pkg, rgbe_ram and rgbe_pack
// header and code bytes do not hold the input; a byte that yields a pixel or an error
//   holds it off until the packer takes that pixel from the read stage
// a run value byte holds the input while its entries (up to 127) are written to its
//   plane or, for channel three, read out as pixels through the read stage to the packer
module rgbe_scanline_rle_decoder #(
  parameter int MAX_WIDTH = 4096
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        byte_valid,
  output logic        byte_stall,
  input  logic [7:0]  data_byte,
  output logic        pixel_valid,
  input  logic        pixel_stall,
  output logic [31:0] red_a,
  output logic [31:0] green_a,
  output logic [31:0] blue_a,
  output logic [31:0] red_b,
  output logic [31:0] green_b,
  output logic [31:0] blue_b,
  output logic        second_valid,
  output logic        row_end,
  output logic        image_end,
  output logic [1:0]  error_code,
  output logic        last
);
  import rgbe_pkg::*;

  localparam int         AW   = $clog2(MAX_WIDTH);
  localparam logic [14:0] MaxW = 15'(MAX_WIDTH);

  // configuration registers
  logic [14:0] image_width, width_new;
  logic [15:0] image_height, height_new;
  logic        cfg_wr, restart;

  // sequencer state
  state_t      state, state_next;
  phase_t      phase, phase_next;
  logic [31:0] header_bytes, header_bytes_next;
  logic [1:0]  channel, channel_next;
  logic [14:0] position, position_next;
  logic [7:0]  count_left, count_left_next;
  logic [15:0] rows_left, rows_left_next;
  logic        error_flag, error_flag_next;
  logic [7:0]  run_val, run_val_next;

  // read stage in front of the packer
  logic        pix_valid;
  pix_t        pix, pix_new;
  logic        pix_take, pix_free, issue;

  // line store access
  logic          we, re;
  logic [AW-1:0] addr;
  logic [7:0]    wdata;
  logic [23:0]   ram_rgb;

  // helpers
  logic        accept;
  logic [31:0] hb_shift;
  logic [14:0] pos_inc;
  logic [15:0] pos_inc16, width16, plane_rem;
  logic [7:0]  cnt;
  logic        row_hit_flat, row_hit_rle, non_rle;
  logic [15:0] rows_dec;

  // apb: writes restart the decoder, reads return the register
  // reset brings the registers back to their reset values
  assign pready     = 1'b1;
  assign cfg_wr     = psel && penable && pwrite;
  assign width_new  = rst ? 15'd8 :
                      (cfg_wr && !paddr[2]) ? pwdata[14:0] : image_width;
  assign height_new = rst ? 16'd0 :
                      (cfg_wr && paddr[2]) ? pwdata[15:0] : image_height;
  assign prdata     = paddr[2] ? {16'd0, image_height} : {17'd0, image_width};
  assign restart    = rst || cfg_wr;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= 15'd8;
      image_height <= 16'd0;
    end else begin
      image_width  <= width_new;
      image_height <= height_new;
    end
  end

  assign accept    = byte_valid && !byte_stall;
  // one byte at a time; a busy read stage also holds the input off
  assign byte_stall = (state != ST_IDLE) || pix_valid;
  assign pix_free  = !pix_valid || pix_take;

  assign hb_shift     = {header_bytes[23:0], data_byte};
  assign pos_inc      = position + 15'd1;
  assign pos_inc16    = {1'b0, position} + 16'd1;
  assign width16      = {1'b0, image_width};
  assign plane_rem    = width16 - {1'b0, position};
  assign row_hit_flat = pos_inc16 >= width16;
  assign row_hit_rle  = pos_inc16 == width16;
  assign cnt          = (data_byte > RUN_BASE) ? data_byte - RUN_BASE : data_byte;
  assign non_rle      = hb_shift[31:24] != 8'd2 || hb_shift[23:16] != 8'd2 || hb_shift[15];
  assign rows_dec     = rows_left - {15'd0, rows_left != 16'd0};

  always_comb begin
    state_next        = state;
    phase_next        = phase;
    header_bytes_next = header_bytes;
    channel_next      = channel;
    position_next     = position;
    count_left_next   = count_left;
    rows_left_next    = rows_left;
    error_flag_next   = error_flag;
    run_val_next      = run_val;
    we                = 1'b0;
    re                = 1'b0;
    addr              = position[AW-1:0];
    wdata             = data_byte;
    issue             = 1'b0;
    pix_new           = '0;

    case (state)
      ST_IDLE: begin
        if (accept && !error_flag && rows_left != 16'd0) begin
          case (phase)
            PH_HDR, PH_FLAT: begin
              header_bytes_next = hb_shift;
              if (count_left == 8'd3) begin
                count_left_next = 8'd0;
                if (phase == PH_FLAT || non_rle) begin
                  // flat pixel straight from the four bytes
                  phase_next       = PH_FLAT;
                  issue            = 1'b1;
                  pix_new.rgb      = hb_shift[31:8];
                  pix_new.expo     = hb_shift[7:0];
                  pix_new.row_end  = row_hit_flat;
                  pix_new.last     = 1'b1;
                  position_next    = row_hit_flat ? 15'd0 : pos_inc;
                end else if (hb_shift[15:0] != width16) begin
                  issue           = 1'b1;
                  pix_new.err     = ERR_WIDTH;
                  pix_new.last    = 1'b1;
                  error_flag_next = 1'b1;
                end else if (image_width > MaxW) begin
                  issue           = 1'b1;
                  pix_new.err     = ERR_STORE;
                  pix_new.last    = 1'b1;
                  error_flag_next = 1'b1;
                end else begin
                  phase_next    = PH_CODE;
                  channel_next  = 2'd0;
                  position_next = 15'd0;
                end
              end else begin
                count_left_next = count_left + 8'd1;
              end
            end
            PH_CODE: begin
              if (cnt == 8'd0 || {8'd0, cnt} > plane_rem) begin
                issue           = 1'b1;
                pix_new.err     = ERR_COUNT;
                pix_new.last    = 1'b1;
                error_flag_next = 1'b1;
              end else begin
                count_left_next = cnt;
                phase_next      = (data_byte > RUN_BASE) ? PH_RUNVAL : PH_LIT;
              end
            end
            PH_RUNVAL: begin
              run_val_next = data_byte;
              state_next   = (channel == 2'd3) ? ST_EMIT : ST_FILL;
            end
            PH_LIT: begin
              if (channel == 2'd3) begin
                re              = 1'b1;
                issue           = 1'b1;
                pix_new.use_ram = 1'b1;
                pix_new.expo    = data_byte;
                pix_new.row_end = row_hit_rle;
                pix_new.last    = 1'b1;
              end else begin
                we = 1'b1;
              end
              position_next   = pos_inc;
              count_left_next = count_left - 8'd1;
              if (count_left == 8'd1) phase_next = PH_CODE;
              // end of the plane
              if (row_hit_flat) begin
                position_next = 15'd0;
                if (channel == 2'd3) begin
                  channel_next = 2'd0;
                  phase_next   = PH_HDR;
                end else begin
                  channel_next = channel + 2'd1;
                end
              end
            end
            default: ;
          endcase
        end
      end
      ST_FILL, ST_EMIT: begin
        if (state == ST_FILL || pix_free) begin
          if (state == ST_FILL) begin
            we    = 1'b1;
            wdata = run_val;
          end else begin
            re              = 1'b1;
            issue           = 1'b1;
            pix_new.use_ram = 1'b1;
            pix_new.expo    = run_val;
            pix_new.row_end = row_hit_rle;
            pix_new.last    = count_left == 8'd1;
          end
          position_next   = pos_inc;
          count_left_next = count_left - 8'd1;
          if (count_left == 8'd1) begin
            state_next = ST_IDLE;
            phase_next = PH_CODE;
            if (row_hit_flat) begin
              position_next = 15'd0;
              if (channel == 2'd3) begin
                channel_next = 2'd0;
                phase_next   = PH_HDR;
              end else begin
                channel_next = channel + 2'd1;
              end
            end
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase

    // a finished row counts down the image
    if (issue && pix_new.row_end) begin
      rows_left_next    = rows_dec;
      pix_new.image_end = rows_dec == 16'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (restart) begin
      state        <= ST_IDLE;
      phase        <= (width_new < 15'd8) ? PH_FLAT : PH_HDR;
      header_bytes <= 32'd0;
      channel      <= 2'd0;
      position     <= 15'd0;
      count_left   <= 8'd0;
      rows_left    <= height_new;
      error_flag   <= 1'b0;
      pix_valid    <= 1'b0;
    end else begin
      state        <= state_next;
      phase        <= phase_next;
      header_bytes <= header_bytes_next;
      channel      <= channel_next;
      position     <= position_next;
      count_left   <= count_left_next;
      rows_left    <= rows_left_next;
      error_flag   <= error_flag_next;
      pix_valid    <= issue || (pix_valid && !pix_take);
    end
  end

  always_ff @(posedge clk) begin
    run_val <= run_val_next;
    if (issue) pix <= pix_new;
  end

  // line store: one plane per colour, read together for channel three;
  // planes are written only for channels zero to two, so no write ever meets a read
  rgbe_ram #(.WIDTH(8), .DEPTH(MAX_WIDTH)) u_red (
    .clk(clk), .we(we && channel == 2'd0), .waddr(addr), .wdata(wdata),
    .re(re), .raddr(addr), .rdata(ram_rgb[23:16])
  );

  rgbe_ram #(.WIDTH(8), .DEPTH(MAX_WIDTH)) u_green (
    .clk(clk), .we(we && channel == 2'd1), .waddr(addr), .wdata(wdata),
    .re(re), .raddr(addr), .rdata(ram_rgb[15:8])
  );

  rgbe_ram #(.WIDTH(8), .DEPTH(MAX_WIDTH)) u_blue (
    .clk(clk), .we(we && channel == 2'd2), .waddr(addr), .wdata(wdata),
    .re(re), .raddr(addr), .rdata(ram_rgb[7:0])
  );

  // float conversion, pairing and the result register
  rgbe_pack u_pack (
    .clk(clk), .rst(rst),
    .pix_valid(pix_valid), .pix(pix), .ram_rgb(ram_rgb), .pix_take(pix_take),
    .pixel_valid(pixel_valid), .pixel_stall(pixel_stall),
    .red_a(red_a), .green_a(green_a), .blue_a(blue_a),
    .red_b(red_b), .green_b(green_b), .blue_b(blue_b),
    .second_valid(second_valid), .row_end(row_end), .image_end(image_end),
    .error_code(error_code), .last(last)
  );

`ifndef ASSERT_OFF
  // the read stage is never overwritten while it still holds a pixel
  a_stage_free: assert property (@(posedge clk) disable iff (rst)
    issue |-> (!pix_valid || pix_take)) else $error("read stage overrun");

  // the store is never written and read in the same cycle
  a_no_rw: assert property (@(posedge clk) disable iff (rst)
    !(we && re)) else $error("line store write meets read");

  // an error transaction leaves the decoder locked
  a_err_sticks: assert property (@(posedge clk) disable iff (restart)
    (issue && pix_new.err != ERR_NONE) |=> error_flag) else $error("error not sticky");
`endif

endmodule
